>>> design/swm_pkg.sv
// Shared types and fixed widths for the sliding window median unit.
package swm_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 32;
  localparam int WSIZE_W  = 6;

  // Window size after reset.
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 6'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the accepted item and fetch the oldest ring entry
    logic remove;  // drop the oldest sample from the sorted cells
    logic insert;  // place the new sample in the sorted cells and the ring
    logic emit;    // load the output register with the median
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;  // window is full after the insert
    logic out_free;    // output register can take a new item this cycle
  } swm_status_t;

endpackage

>>> design/swm_ram.sv
// Generic single-port-write, registered-read RAM.
module swm_ram
  #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
  )
  (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]               wdata,
    input  logic                           re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]               rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/swm_datapath.sv
// Datapath: window size register, arrival ring, sorted cell chain and output register.
module swm_datapath
  import swm_pkg::*;
  #(
    parameter int WINDOW_MAX = 32
  )
  (
    input  logic                       clk,
    input  logic                       rst,
    input  logic                       cfg_wr_en,
    input  logic [WSIZE_W-1:0]         cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  swm_cmd_t                   cmd,
    output swm_status_t                status,
    output logic signed [SAMPLE_W-1:0] median,
    output logic                       median_valid,
    input  logic                       median_ready
  );

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = (CW > WSIZE_W) ? CW : WSIZE_W;

  logic [WSIZE_W-1:0]         window_size;
  logic [CW-1:0]              fill_count;
  logic [PW-1:0]              oldest_pointer;
  logic [PW-1:0]              slot;
  logic signed [SAMPLE_W-1:0] key;
  logic                       was_full;
  logic signed [SAMPLE_W-1:0] cells [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] cells_next [WINDOW_MAX];

  logic [CW-1:0]              eff_size;
  logic [SW-1:0]              ws_ext;
  logic                       full;
  logic [CW:0]                slot_sum;
  logic [CW:0]                slot_wrap;
  logic [CW-1:0]              ins_count;
  logic [CW-1:0]              mid_rank;
  logic [SAMPLE_W-1:0]        old_raw;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic [WINDOW_MAX-1:0]      shift_down;
  logic [WINDOW_MAX-1:0]      ge_pos;

  // Effective window size: zero acts as one, large values saturate.
  always_comb begin
    ws_ext = SW'(window_size);
    if (window_size == '0) begin
      eff_size = CW'(1);
    end else if (ws_ext > SW'(WINDOW_MAX)) begin
      eff_size = CW'(WINDOW_MAX);
    end else begin
      eff_size = CW'(ws_ext);
    end
  end

  assign full = (fill_count == eff_size);

  // Ring slot of the new sample: the oldest slot when full, else the next free one.
  always_comb begin
    slot_sum = (CW+1)'(oldest_pointer) + (CW+1)'(fill_count);
    if (slot_sum >= (CW+1)'(eff_size)) begin
      slot_wrap = slot_sum - (CW+1)'(eff_size);
    end else begin
      slot_wrap = slot_sum;
    end
  end

  // Arrival ring: read the oldest entry on load, write the new one on insert.
  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (slot),
    .wdata (key),
    .re    (cmd.load),
    .raddr (oldest_pointer),
    .rdata (old_raw)
  );

  assign old_sample = signed'(old_raw);

  // Insert count: the window less the removed sample when full.
  assign ins_count = was_full ? (eff_size - CW'(1)) : fill_count;

  // Per-cell decisions; the cells are sorted so each flag is a simple compare.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      shift_down[i] = (cells[i] >= old_sample) && (CW'(i) < eff_size);
      ge_pos[i]     = (cells[i] > key) || (CW'(i) >= ins_count);
    end
  end

  // Next value of the sorted cell chain.
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cells_next[i] = cells[i];
    end
    if (cmd.remove && was_full) begin
      for (int i = 0; i < WINDOW_MAX - 1; i++) begin
        if (shift_down[i]) begin
          cells_next[i] = cells[i+1];
        end
      end
    end else if (cmd.insert) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (ge_pos[i]) begin
          if (i == 0) begin
            cells_next[i] = key;
          end else if (!ge_pos[i-1]) begin
            cells_next[i] = key;
          end else begin
            cells_next[i] = cells[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= sample;
      was_full <= full;
      slot     <= PW'(slot_wrap);
    end
  end

  // Window size, fill count and oldest pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= WSIZE_RESET;
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (cfg_wr_en) begin
      window_size    <= cfg_wr_data;
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (cmd.insert) begin
      if (was_full) begin
        if ((CW'(oldest_pointer) + CW'(1)) == eff_size) begin
          oldest_pointer <= '0;
        end else begin
          oldest_pointer <= oldest_pointer + PW'(1);
        end
      end else begin
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  // Lower median sits at rank ceil(size/2), index (size-1)/2.
  assign mid_rank = (eff_size - CW'(1)) >> 1;

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      median <= cells[PW'(mid_rank)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (cmd.emit) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  assign status.has_result = full;
  assign status.out_free   = !median_valid || median_ready;

endmodule

>>> design/swm_ctrl.sv
// Controller: sequences fetch, remove, insert and output of one item.
module swm_ctrl
  import swm_pkg::*;
  (
    input  logic        clk,
    input  logic        rst,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
  );

  typedef enum logic [1:0] {
    IDLE,
    REMOVE,
    INSERT,
    FINISH
  } state_t;

  state_t state;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (sample_valid) begin
            state <= REMOVE;
          end
        end
        REMOVE: begin
          state <= INSERT;
        end
        INSERT: begin
          state <= FINISH;
        end
        FINISH: begin
          if (!status.has_result || status.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  assign sample_ready = (state == IDLE);
  assign cmd.load     = (state == IDLE) && sample_valid;
  assign cmd.remove   = (state == REMOVE);
  assign cmd.insert   = (state == INSERT);
  assign cmd.emit     = (state == FINISH) && status.has_result && status.out_free;

endmodule

>>> design/sliding_window_median_unit.sv
// Sliding window median unit: a lower-median filter over a configurable sample window.
// Each item passes four steps: accept with ring fetch, remove of the oldest sample,
// insert into the sorted cell chain, then output; a stalled output holds the last step.
// A new sample is accepted only in the idle state, after the output step is done.
// Synchronous reset sets the window size to 3 and empties the window; a write to
// the window size register also empties the window.
module sliding_window_median_unit
  import swm_pkg::*;
  #(
    parameter int WINDOW_MAX = 32
  )
  (
    input  logic                       clk,
    input  logic                       rst,
    input  logic                       cfg_wr_en,
    input  logic [WSIZE_W-1:0]         cfg_wr_data,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       median_valid,
    input  logic                       median_ready,
    output logic signed [SAMPLE_W-1:0] median
  );

  swm_cmd_t    cmd;
  swm_status_t status;

  // Sequencer.
  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Window storage and output register.
  swm_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .median       (median),
    .median_valid (median_valid),
    .median_ready (median_ready)
  );

endmodule

>>> bench/sliding_window_median_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window median unit with random stalls on both sides.
module sliding_window_median_unit_tb;
  import swm_pkg::*;

  localparam int WINDOW_LIMIT = 32;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 12;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [WSIZE_W-1:0]         cfg_wr_data;
  logic                       sample_valid;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       median_valid;
  logic                       median_ready;
  logic signed [SAMPLE_W-1:0] median;

  // Predictor state: register copy, window in arrival order and in ascending order.
  logic [WSIZE_W-1:0] cfg_window_size;
  int arrival_q[$];
  int ascending_q[$];
  int expected_medians[$];

  int sender_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;
  int stall_cycles;
  int error_count;
  int samples_sent;
  int medians_checked;

  sliding_window_median_unit #(.WINDOW_MAX(WINDOW_LIMIT)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .median_valid (median_valid),
    .median_ready (median_ready),
    .median       (median)
  );

  // Clock generation.
  always #10 clk = ~clk;

  // Window length actually used: zero acts as one, large values saturate.
  function automatic int eff_window();
    if (cfg_window_size == '0) begin
      return 1;
    end
    if (int'(cfg_window_size) > WINDOW_LIMIT) begin
      return WINDOW_LIMIT;
    end
    return int'(cfg_window_size);
  endfunction

  // Slide the window by one sample and queue the lower median once it is full.
  task automatic predict_median(input int value);
    int width;
    int oldest;
    int pos;
    width = eff_window();
    if (arrival_q.size() == width) begin
      oldest = arrival_q.pop_front();
      // Any equal entry may go; the sorted contents come out the same.
      for (int i = 0; i < ascending_q.size(); i++) begin
        if (ascending_q[i] == oldest) begin
          ascending_q.delete(i);
          break;
        end
      end
    end
    arrival_q.insert(arrival_q.size(), value);
    pos = ascending_q.size();
    while (pos > 0 && ascending_q[pos-1] > value) begin
      pos--;
    end
    ascending_q.insert(pos, value);
    if (arrival_q.size() == width) begin
      expected_medians.insert(expected_medians.size(), ascending_q[(width + 1) / 2 - 1]);
    end
  endtask

  // Offer one item, with an optional idle gap in front, and wait until it is taken.
  task automatic send_sample(input int value);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(4, 1);
    end
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (!sample_ready);
    samples_sent++;
    predict_median(value);
  endtask

  // Drop valid after the last item of a burst.
  task automatic end_burst();
    @(negedge clk);
    sample_valid <= 1'b0;
  endtask

  // Wait for every expected median, then let an item with no result finish.
  task automatic wait_drain();
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window size; the block and the predictor both empty the window.
  task automatic write_window_size(input logic [WSIZE_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_window_size = value;
    arrival_q.delete();
    ascending_q.delete();
  endtask

  // Random sample: many small values for ties, some near the range ends, the rest anywhere.
  function automatic int rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return int'($urandom_range(16)) - 8;
    end
    if (pick < 40) begin
      if ($urandom_range(1) == 1) begin
        return 32'h7FFF_FFFF - int'($urandom_range(3));
      end
      return 32'h8000_0000 + int'($urandom_range(3));
    end
    return int'($urandom);
  endfunction

  // Send a burst of random items, then close it and wait for the medians.
  task automatic send_random_burst(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(rand_sample());
    end
    end_burst();
    wait_drain();
  endtask

  // Range ends, ties and odd/even windows at the reset size and at small sizes.
  task automatic test_directed_extremes();
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(5);
    send_sample(5);
    send_sample(5);
    end_burst();
    wait_drain();
    // Size zero behaves as a window of one.
    write_window_size(6'd0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    end_burst();
    wait_drain();
    write_window_size(6'd1);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    end_burst();
    wait_drain();
    // Even window: the lower of the two middle samples.
    write_window_size(6'd2);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(-3);
    send_sample(-3);
    end_burst();
    wait_drain();
  endtask

  // A register write in the middle of filling must throw away the partial window.
  task automatic test_partial_fill_clear();
    write_window_size(6'd3);
    send_sample(100);
    send_sample(-100);
    end_burst();
    wait_drain();
    write_window_size(6'd3);
    send_sample(7);
    send_sample(9);
    send_sample(8);
    end_burst();
    wait_drain();
  endtask

  // Largest window, saturation above it, and the smallest windows.
  task automatic test_window_extremes();
    logic [WSIZE_W-1:0] sizes [5];
    sizes = '{6'd32, 6'd33, 6'd63, 6'd0, 6'd1};
    foreach (sizes[i]) begin
      write_window_size(sizes[i]);
      send_random_burst(eff_window() + 8);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    write_window_size(6'd4);
    hold_request = 300;
    send_random_burst(40);
  endtask

  // Sender stops until every median is back, then continues in the same window.
  task automatic test_sender_pause();
    write_window_size(6'd5);
    for (int i = 0; i < 20; i++) begin
      send_sample(rand_sample());
    end
    end_burst();
    while (expected_medians.size() != 0) @(posedge clk);
    send_random_burst(20);
  endtask

  // Random window sizes, mostly small, with bursts of random content.
  task automatic test_random_windows(input int item_goal);
    int sent_here;
    int burst_len;
    logic [WSIZE_W-1:0] size_pick;
    sent_here = 0;
    while (sent_here < item_goal) begin
      if ($urandom_range(99) < 75) begin
        size_pick = WSIZE_W'($urandom_range(9));
      end else begin
        size_pick = WSIZE_W'($urandom_range(63));
      end
      write_window_size(size_pick);
      burst_len = eff_window() + int'($urandom_range(30, 4));
      send_random_burst(burst_len);
      sent_here += burst_len;
    end
  endtask

  // Result side: random ready, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      median_ready <= 1'b0;
    end else begin
      median_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted median with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && median_valid && median_ready) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected median, expected none, actual %0d", $time, median);
        error_count++;
      end else begin
        medians_checked++;
        if (median !== expected_medians[0]) begin
          $display("%0t: median mismatch, expected %0d, actual %0d",
                   $time, expected_medians[0], median);
          error_count++;
        end
        void'(expected_medians.pop_front());
      end
    end
  end

  // Watchdog: too long without any item moving on either side.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (median_valid && median_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    sample_valid    = 1'b0;
    sample          = '0;
    median_ready    = 1'b0;
    cfg_window_size = WSIZE_RESET;
    hold_request    = 0;
    hold_left       = 0;
    stall_cycles    = 0;
    error_count     = 0;
    samples_sent    = 0;
    medians_checked = 0;
    sender_idle_pct = 15;
    recv_idle_pct   = 46;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_partial_fill_clear();
    test_window_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_windows(270);

    sender_idle_pct = 46;
    recv_idle_pct   = 15;
    test_random_windows(270);

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    test_random_windows(270);

    wait_drain();
    if (expected_medians.size() != 0) begin
      $display("%0t: %0d medians never arrived", $time, expected_medians.size());
      error_count++;
    end
    $display("Run covered %0d samples and %0d medians checked,", samples_sent, medians_checked);
    $display("window sizes 0 to 63 with saturation, ties, range ends and long stalls.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
design/swm_pkg.sv
design/swm_ram.sv
design/swm_datapath.sv
design/swm_ctrl.sv
design/sliding_window_median_unit.sv
bench/sliding_window_median_unit_tb.sv
